>>> sv/skip_sequence_word_search_unit_defines.svh
`ifndef SKIP_SEQUENCE_WORD_SEARCH_UNIT_DEFINES_SVH
`define SKIP_SEQUENCE_WORD_SEARCH_UNIT_DEFINES_SVH
// clocked assertion, quiet during reset
`define SSWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never hold, quiet during reset
`define SSWS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

>>> sv/ssws_pkg.sv
package ssws_pkg;
  localparam int MAX_WORD_LEN = 16;
  localparam int MAX_SKIP     = 100;
  localparam int DICT_WORDS   = 16;
  localparam int SPAN         = MAX_SKIP * MAX_WORD_LEN;
  localparam int TEXT_AW      = 11;
  localparam int DICT_AW      = 8;
  localparam int RESULT_LIMIT = 64;

  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_DICT = 1'b1;

  localparam logic CFG_SKIP_LOW  = 1'b0;
  localparam logic CFG_SKIP_HIGH = 1'b1;

  typedef struct packed {
    logic               text_we;
    logic [TEXT_AW-1:0] text_addr;
    logic [7:0]         text_data;
    logic               dict_we;
    logic [3:0]         dict_slot;
    logic [3:0]         dict_pos;
    logic [7:0]         dict_data;
    logic [4:0]         dict_len;
  } wr_t;
endpackage

>>> sv/skip_sequence_word_search_unit.sv
// skip-sequence word search: load dictionary letters with req_type 1, then stream
// text with req_type 0. once 1601 characters have arrived, each text character
// queues the search of the start position 1600 characters back: every used word
// is tried at each skip in [skip_low, skip_high], each letter read in S_RD and
// compared in S_CMP through the text and dictionary memory ports, stopping at the
// first mismatch. each used word and skip passes through S_NEXT, S_RD and S_CMP,
// each further letter through S_RD and S_CMP again and an unused slot through
// S_NEXT alone; a position is picked up in S_IDLE and closed in S_FIN.
// each request is registered in the input stage and start is ignored while busy is
// high, so no new request is taken until the held one is passed on. up to two
// positions wait in a queue; busy is high while the input stage holds a request
// (text waits for queue room, dictionary writes wait for the search to drain).
// results appear for one cycle on strobe and the receiver cannot stall them; the
// last result of a position has last_match set, and overflow marks dropped matches
module skip_sequence_word_search_unit (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  char_value,
  input  logic [3:0]  word_slot,
  input  logic [3:0]  letter_pos,
  input  logic [4:0]  word_length,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [6:0]  cfg_wdata,
  // results
  output logic        strobe,
  output logic [3:0]  found_word,
  output logic [31:0] start_position,
  output logic [6:0]  spacing,
  output logic        last_match,
  output logic        overflow
);
  logic [6:0]    skip_low;
  logic [6:0]    skip_high;
  logic [6:0]    lo;
  logic [6:0]    hi;
  logic          back_idle;
  logic          fifo_full;
  logic          fifo_empty;
  logic          push;
  logic [31:0]   push_start;
  logic          pop;
  logic [31:0]   pop_start;
  ssws_pkg::wr_t wr;

  // skip registers
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_low  <= 7'd1;
      skip_high <= 7'd100;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ssws_pkg::CFG_SKIP_LOW:  skip_low  <= cfg_wdata;
        ssws_pkg::CFG_SKIP_HIGH: skip_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero low skip acts as one, high skip clipped to the built maximum
  assign lo = (skip_low == 7'd0) ? 7'd1 : skip_low;
  assign hi = (skip_high > 7'(ssws_pkg::MAX_SKIP)) ? 7'(ssws_pkg::MAX_SKIP) : skip_high;

  ssws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .char_value (char_value),
    .word_slot  (word_slot),
    .letter_pos (letter_pos),
    .word_length(word_length),
    .back_idle  (back_idle),
    .fifo_full  (fifo_full),
    .fifo_empty (fifo_empty),
    .push       (push),
    .push_start (push_start),
    .wr         (wr)
  );

  // queue of start positions awaiting search
  ssws_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_start),
    .pop      (pop),
    .pop_data (pop_start),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  ssws_back u_back (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .fifo_empty    (fifo_empty),
    .fifo_data     (pop_start),
    .pop           (pop),
    .lo            (lo),
    .hi            (hi),
    .back_idle     (back_idle),
    .strobe        (strobe),
    .found_word    (found_word),
    .start_position(start_position),
    .spacing       (spacing),
    .last_match    (last_match),
    .overflow      (overflow)
  );
endmodule

>>> sv/ssws_fifo.sv
module ssws_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] push_data,
  input  logic        pop,
  output logic [31:0] pop_data,
  output logic        full,
  output logic        empty
);
  logic [31:0] mem [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end
endmodule

>>> sv/ssws_front.sv
module ssws_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic           req_type,
  input  logic [7:0]     char_value,
  input  logic [3:0]     word_slot,
  input  logic [3:0]     letter_pos,
  input  logic [4:0]     word_length,
  input  logic           back_idle,
  input  logic           fifo_full,
  input  logic           fifo_empty,
  output logic           push,
  output logic [31:0]    push_start,
  output ssws_pkg::wr_t  wr
);
  logic        hold_valid;
  logic        h_type;
  logic [7:0]  h_char;
  logic [3:0]  h_slot;
  logic [3:0]  h_pos;
  logic [4:0]  h_len;
  logic [31:0] chars_seen;
  logic [31:0] chars_seen_next;
  logic        primed;
  logic        go;

  assign busy            = hold_valid;
  assign chars_seen_next = chars_seen + 32'd1;

  always_comb begin
    go = 1'b0;
    if (hold_valid) begin
      // dictionary changes wait until every queued search has finished
      if (h_type == ssws_pkg::REQ_DICT) begin
        go = back_idle && fifo_empty;
      end else begin
        go = !fifo_full;
      end
    end
  end

  always_comb begin
    wr.text_we   = go && (h_type == ssws_pkg::REQ_TEXT);
    wr.text_addr = chars_seen[ssws_pkg::TEXT_AW-1:0];
    wr.text_data = h_char;
    wr.dict_we   = go && (h_type == ssws_pkg::REQ_DICT)
                   && ({1'b0, h_slot} < 5'(ssws_pkg::DICT_WORDS))
                   && ({1'b0, h_pos} < 5'(ssws_pkg::MAX_WORD_LEN));
    wr.dict_slot = h_slot;
    wr.dict_pos  = h_pos;
    wr.dict_data = h_char;
    wr.dict_len  = (h_len > 5'(ssws_pkg::MAX_WORD_LEN)) ?
                   5'(ssws_pkg::MAX_WORD_LEN) : h_len;
  end

  assign push = wr.text_we &&
                (primed || (chars_seen_next == 32'(ssws_pkg::SPAN + 1)));
  assign push_start = chars_seen_next - 32'(ssws_pkg::SPAN + 1);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      h_type <= req_type;
      h_char <= char_value;
      h_slot <= word_slot;
      h_pos  <= letter_pos;
      h_len  <= word_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      chars_seen <= 32'd0;
      primed     <= 1'b0;
    end else begin
      if (start && !busy) begin
        hold_valid <= 1'b1;
      end else if (go) begin
        hold_valid <= 1'b0;
      end
      if (wr.text_we) begin
        chars_seen <= chars_seen_next;
        if (push) begin
          primed <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/ssws_back.sv
`include "skip_sequence_word_search_unit_defines.svh"
module ssws_back (
  input  logic           clk,
  input  logic           rst,
  input  ssws_pkg::wr_t  wr,
  input  logic           fifo_empty,
  input  logic [31:0]    fifo_data,
  output logic           pop,
  input  logic [6:0]     lo,
  input  logic [6:0]     hi,
  output logic           back_idle,
  output logic           strobe,
  output logic [3:0]     found_word,
  output logic [31:0]    start_position,
  output logic [6:0]     spacing,
  output logic           last_match,
  output logic           overflow
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [7:0]  text_mem [2**ssws_pkg::TEXT_AW];
  logic [7:0]  dict_mem [2**ssws_pkg::DICT_AW];
  logic [4:0]  dict_len [ssws_pkg::DICT_WORDS];
  logic [7:0]  text_q;
  logic [7:0]  dict_q;

  logic [2:0]  state;
  logic [31:0] cur_start;
  logic [3:0]  slot;
  logic [6:0]  skip;
  logic [3:0]  k;
  logic [ssws_pkg::TEXT_AW-1:0] tpos;
  logic [5:0]  count;
  logic        have_pend;
  logic [3:0]  pend_slot;
  logic [6:0]  pend_skip;
  logic [4:0]  len_cur;

  assign back_idle = (state == S_IDLE);
  assign pop       = (state == S_IDLE) && !fifo_empty;
  assign len_cur   = dict_len[slot];

  always_ff @(posedge clk) begin
    if (wr.text_we) begin
      text_mem[wr.text_addr] <= wr.text_data;
    end
    text_q <= text_mem[tpos];
  end

  always_ff @(posedge clk) begin
    if (wr.dict_we) begin
      dict_mem[{wr.dict_slot, wr.dict_pos}] <= wr.dict_data;
    end
    dict_q <= dict_mem[{slot, k}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ssws_pkg::DICT_WORDS; i++) begin
        dict_len[i] <= 5'd0;
      end
    end else if (wr.dict_we) begin
      dict_len[wr.dict_slot] <= wr.dict_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      have_pend <= 1'b0;
      count     <= 6'd0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!fifo_empty) begin
            cur_start <= fifo_data;
            slot      <= 4'd0;
            skip      <= lo;
            count     <= 6'd0;
            have_pend <= 1'b0;
            state     <= (lo > hi) ? S_FIN : S_NEXT;
          end
        end
        S_NEXT: begin
          k    <= 4'd0;
          tpos <= cur_start[ssws_pkg::TEXT_AW-1:0];
          if (len_cur == 5'd0) begin
            if (slot == 4'(ssws_pkg::DICT_WORDS - 1)) begin
              state <= S_FIN;
            end else begin
              slot <= 4'(slot + 4'd1);
              skip <= lo;
            end
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if ((text_q == dict_q) && (5'({1'b0, k} + 5'd1) != len_cur)) begin
            k     <= 4'(k + 4'd1);
            tpos  <= ssws_pkg::TEXT_AW'(tpos + {4'd0, skip});
            state <= S_RD;
          end else begin
            priority if ((text_q == dict_q) && have_pend
                         && (count == 6'(ssws_pkg::RESULT_LIMIT - 1))) begin
              // one match beyond the limit: close with the overflow mark
              strobe         <= 1'b1;
              found_word     <= pend_slot;
              spacing        <= pend_skip;
              start_position <= cur_start;
              last_match     <= 1'b1;
              overflow       <= 1'b1;
              have_pend      <= 1'b0;
              state          <= S_IDLE;
            end else begin
              if (text_q == dict_q) begin
                pend_slot <= slot;
                pend_skip <= skip;
                have_pend <= 1'b1;
                if (have_pend) begin
                  strobe         <= 1'b1;
                  found_word     <= pend_slot;
                  spacing        <= pend_skip;
                  start_position <= cur_start;
                  last_match     <= 1'b0;
                  overflow       <= 1'b0;
                  count          <= 6'(count + 6'd1);
                end
              end
              if (skip == hi) begin
                if (slot == 4'(ssws_pkg::DICT_WORDS - 1)) begin
                  state <= S_FIN;
                end else begin
                  slot  <= 4'(slot + 4'd1);
                  skip  <= lo;
                  state <= S_NEXT;
                end
              end else begin
                skip  <= 7'(skip + 7'd1);
                state <= S_NEXT;
              end
            end
          end
        end
        S_FIN: begin
          if (have_pend) begin
            strobe         <= 1'b1;
            found_word     <= pend_slot;
            spacing        <= pend_skip;
            start_position <= cur_start;
            last_match     <= 1'b1;
            overflow       <= 1'b0;
          end
          have_pend <= 1'b0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SSWS_ASSERT(a_ovf_is_last, strobe && overflow |-> last_match, "overflow without last")
  `SSWS_ASSERT(a_k_in_word, state == S_CMP |-> ({1'b0, k} < len_cur), "letter beyond word")
  `SSWS_ASSERT(a_idle_no_pend, state == S_IDLE |-> !have_pend, "pending result lost")
  `SSWS_NEVER(a_skip_range, (state == S_CMP) && ((skip < lo) || (skip > hi)), "skip off range")
endmodule
